// ----- rtl/ppu_pkg.sv -----
`default_nettype none

package ppu_pkg;

  // field widths
  localparam int unsigned POS_W   = 32;
  localparam int unsigned VEL_W   = 16;
  localparam int unsigned AGE_W   = 16;
  localparam int unsigned SLOT_W  = 5;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CFG_IDX_W = 1;

  // stream word widths
  localparam int unsigned IN_DATA_W  = 112;
  localparam int unsigned OUT_DATA_W = 72;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENGINE_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENGINE_Y = 1'b1;

  // operation codes (s_axis_tuser)
  localparam logic OP_SPAWN = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // result kinds (m_axis_tuser)
  localparam logic KIND_SPAWN = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  // one slot as held in the slot RAM
  typedef struct packed {
    logic [POS_W-1:0] loc_x;
    logic [POS_W-1:0] loc_y;
    logic [VEL_W-1:0] vel_x;
    logic [VEL_W-1:0] vel_y;
    logic [AGE_W-1:0] age;
    logic [AGE_W-1:0] life;
  } slot_entry_t;

  localparam int unsigned ENTRY_W = $bits(slot_entry_t);

endpackage

`default_nettype wire

// ----- rtl/ppu_ram.sv -----
`default_nettype none

module ppu_ram #(
  parameter int unsigned WIDTH = 128,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          we_i,
  input  wire logic                                          re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  addr_i,
  input  wire logic [WIDTH-1:0]                              wdata_i,
  output logic      [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/particle_pool_update.sv -----
// Spawn: scan slots from 0 up to the first dead one, then two adder passes
//   (world x, world y) and the write-back; a rejected spawn scans every slot first.
// Tick: per slot a RAM read, load, four passes of the one 32-bit adder and
//   write-back, which waits for a free output register; one item at a time.
// Reset (async, active low) kills every slot, marks every RAM entry unwritten
//   (unwritten entries read as zero) and clears the engine offset. No clear pass.
`default_nettype none

module particle_pool_update #(
  parameter int unsigned SLOT_COUNT = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,

  // config write port
  input  wire logic                          cfg_we_i,
  input  wire logic [ppu_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [ppu_pkg::CFG_W-1:0]     cfg_data_i,

  // input words
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: life_count[15:0], start_x[47:16], start_y[79:48],
  //        speed_x[95:80], speed_y[111:96]
  input  wire logic [ppu_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // tuser: operation (0 spawn, 1 tick)
  input  wire logic                          s_axis_tuser,

  // result words
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // tdata: accepted[0], slot[5:1], alive[6], world_x[38:7],
  //        world_y[70:39], zero[71]
  output logic [ppu_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // tuser: kind (0 spawn reply, 1 tick report)
  output logic                               m_axis_tuser,
  output logic                               m_axis_tlast
);

  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_LOAD,
    S_ADD_LX,
    S_ADD_LY,
    S_ADD_WX,
    S_ADD_WY,
    S_WRITE,
    S_REJECT
  } state_e;

  state_e state_q;

  // engine offset
  logic [ppu_pkg::POS_W-1:0] engine_x_q;
  logic [ppu_pkg::POS_W-1:0] engine_y_q;

  // accepted input word
  logic                      op_q;
  logic [ppu_pkg::AGE_W-1:0] in_life_q;
  logic [ppu_pkg::POS_W-1:0] in_sx_q;
  logic [ppu_pkg::POS_W-1:0] in_sy_q;
  logic [ppu_pkg::VEL_W-1:0] in_vx_q;
  logic [ppu_pkg::VEL_W-1:0] in_vy_q;

  // per-slot flags in flops
  logic [SLOT_COUNT-1:0] alive_q;
  logic [SLOT_COUNT-1:0] written_q;

  // sequencer
  logic [IDX_W-1:0] idx_q;
  logic             rd_written_q;

  // working copy of the current slot
  ppu_pkg::slot_entry_t      work_q;
  logic                      move_q;
  logic                      alive_new_q;
  logic [ppu_pkg::POS_W-1:0] wx_q;
  logic [ppu_pkg::POS_W-1:0] wy_q;

  // output register
  logic                          out_valid_q;
  logic [ppu_pkg::OUT_DATA_W-1:0] out_data_q;
  logic                          out_kind_q;
  logic                          out_last_q;

  logic out_free;
  assign out_free = !out_valid_q || m_axis_tready;

  // a new result word enters the output register
  logic out_load;
  assign out_load = ((state_q == S_WRITE) || (state_q == S_REJECT)) && out_free;

  // slot RAM
  logic                              ram_we;
  logic                              ram_re;
  logic [ppu_pkg::ENTRY_W-1:0]       ram_rdata;
  ppu_pkg::slot_entry_t              rd_entry;

  assign ram_we = (state_q == S_WRITE) && out_free;
  assign ram_re = (state_q == S_READ);

  ppu_ram #(
    .WIDTH (ppu_pkg::ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (idx_q),
    .wdata_i (work_q),
    .rdata_o (ram_rdata)
  );

  // never-written entries read as zero
  assign rd_entry = rd_written_q ? ppu_pkg::slot_entry_t'(ram_rdata) : '0;

  // age step and death check for the tick
  logic [ppu_pkg::AGE_W-1:0] age_next;
  logic                      alive_next;
  assign age_next   = (rd_entry.age == ppu_pkg::AGE_MAX) ? rd_entry.age
                                                         : rd_entry.age + 1'b1;
  assign alive_next = alive_q[idx_q] && (age_next < rd_entry.life);

  // the one shared adder
  logic [ppu_pkg::POS_W-1:0] add_a;
  logic [ppu_pkg::POS_W-1:0] add_b;
  logic [ppu_pkg::POS_W-1:0] add_sum;

  always_comb begin
    add_a = work_q.loc_x;
    add_b = '0;
    case (state_q)
      S_ADD_LX: begin
        add_a = work_q.loc_x;
        add_b = move_q ? ppu_pkg::POS_W'(signed'(work_q.vel_x)) : '0;
      end
      S_ADD_LY: begin
        add_a = work_q.loc_y;
        add_b = move_q ? ppu_pkg::POS_W'(signed'(work_q.vel_y)) : '0;
      end
      S_ADD_WX: begin
        add_a = work_q.loc_x;
        add_b = engine_x_q;
      end
      S_ADD_WY: begin
        add_a = work_q.loc_y;
        add_b = engine_y_q;
      end
      default: begin
        add_a = work_q.loc_x;
        add_b = '0;
      end
    endcase
  end

  assign add_sum = add_a + add_b;

  // reported slot number: low five bits of the index
  logic [IDX_W+ppu_pkg::SLOT_W-1:0] idx_wide;
  logic [ppu_pkg::SLOT_W-1:0]       slot_num;
  assign idx_wide = (IDX_W + ppu_pkg::SLOT_W)'(idx_q);
  assign slot_num = idx_wide[ppu_pkg::SLOT_W-1:0];

  logic is_tick;
  assign is_tick = (op_q == ppu_pkg::OP_TICK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      engine_x_q   <= '0;
      engine_y_q   <= '0;
      op_q         <= ppu_pkg::OP_SPAWN;
      in_life_q    <= '0;
      in_sx_q      <= '0;
      in_sy_q      <= '0;
      in_vx_q      <= '0;
      in_vy_q      <= '0;
      alive_q      <= '0;
      written_q    <= '0;
      idx_q        <= '0;
      rd_written_q <= 1'b0;
      work_q       <= '0;
      move_q       <= 1'b0;
      alive_new_q  <= 1'b0;
      wx_q         <= '0;
      wy_q         <= '0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
      out_kind_q   <= ppu_pkg::KIND_SPAWN;
      out_last_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ppu_pkg::CFG_ENGINE_X: engine_x_q <= cfg_data_i;
          ppu_pkg::CFG_ENGINE_Y: engine_y_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op_q      <= s_axis_tuser;
            in_life_q <= s_axis_tdata[15:0];
            in_sx_q   <= s_axis_tdata[47:16];
            in_sy_q   <= s_axis_tdata[79:48];
            in_vx_q   <= s_axis_tdata[95:80];
            in_vy_q   <= s_axis_tdata[111:96];
            idx_q     <= '0;
            state_q   <= (s_axis_tuser == ppu_pkg::OP_TICK) ? S_READ : S_SCAN;
          end
        end

        // spawn: walk slots up to the first dead one
        S_SCAN: begin
          if (!alive_q[idx_q]) begin
            work_q.loc_x <= in_sx_q;
            work_q.loc_y <= in_sy_q;
            work_q.vel_x <= in_vx_q;
            work_q.vel_y <= in_vy_q;
            work_q.age   <= '0;
            work_q.life  <= in_life_q;
            alive_new_q  <= 1'b1;
            move_q       <= 1'b0;
            state_q      <= S_ADD_WX;
          end else if (idx_q == LAST_IDX) begin
            state_q <= S_REJECT;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end

        S_READ: begin
          rd_written_q <= written_q[idx_q];
          state_q      <= S_LOAD;
        end

        S_LOAD: begin
          work_q.loc_x <= rd_entry.loc_x;
          work_q.loc_y <= rd_entry.loc_y;
          work_q.vel_x <= rd_entry.vel_x;
          work_q.vel_y <= rd_entry.vel_y;
          work_q.age   <= age_next;
          work_q.life  <= rd_entry.life;
          move_q       <= alive_q[idx_q];
          alive_new_q  <= alive_next;
          state_q      <= S_ADD_LX;
        end

        S_ADD_LX: begin
          work_q.loc_x <= add_sum;
          state_q      <= S_ADD_LY;
        end

        S_ADD_LY: begin
          work_q.loc_y <= add_sum;
          state_q      <= S_ADD_WX;
        end

        S_ADD_WX: begin
          wx_q    <= add_sum;
          state_q <= S_ADD_WY;
        end

        S_ADD_WY: begin
          wy_q    <= add_sum;
          state_q <= S_WRITE;
        end

        // write back the slot and post its result word
        S_WRITE: begin
          if (out_free) begin
            alive_q[idx_q]   <= alive_new_q;
            written_q[idx_q] <= 1'b1;
            out_kind_q       <= is_tick ? ppu_pkg::KIND_TICK : ppu_pkg::KIND_SPAWN;
            out_data_q       <= {1'b0, wy_q, wx_q, alive_new_q, slot_num, !is_tick};
            if (!is_tick || idx_q == LAST_IDX) begin
              out_last_q <= 1'b1;
              state_q    <= S_IDLE;
            end else begin
              out_last_q <= 1'b0;
              idx_q      <= idx_q + 1'b1;
              state_q    <= S_READ;
            end
          end
        end

        // pool full
        S_REJECT: begin
          if (out_free) begin
            out_kind_q  <= ppu_pkg::KIND_SPAWN;
            out_data_q  <= '0;
            out_last_q  <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire
